// ===== hdl/framebuffer_draw_engine_assert.svh =====
// Assertion macros for the framebuffer draw engine.
// FDE_ASSERT_NOW checks the consequent in the same cycle, FDE_ASSERT_NEXT in the cycle after.
`ifndef FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FDE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framebuffer_draw_engine: same-cycle check failed");
`define FDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framebuffer_draw_engine: next-cycle check failed");
`else
`define FDE_ASSERT_NOW(label, ante, cons)
`define FDE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/fde_pkg.sv =====
package fde_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COLOR_W = 24;
  localparam int DIM_W   = 9;
  localparam int FIELD_W = 11;
  localparam int CNT_W   = 17;
  // signed coordinate: holds anchor+offset sums and dimensions up to 8191
  localparam int CW      = 14;

  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_OVERLAY = 3'd2,
    ACT_PATTERN = 3'd3,
    ACT_FILL    = 3'd4,
    ACT_OUTLINE = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_TRANSP = 2'd2
  } cfg_reg_t;

  function automatic logic in_frame(input coord_t r, input coord_t c,
                                    input coord_t h, input coord_t w);
    return (r >= 0) && (r < h) && (c >= 0) && (c < w);
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input coord_t r, input coord_t c);
    return ADDR_W'(ADDR_W'(r[ROW_BITS-1:0]) * ADDR_W'(MAX_WIDTH))
         + ADDR_W'(c[COL_BITS-1:0]);
  endfunction

endpackage

// ===== hdl/framebuffer_draw_engine.sv =====
// Channel   Direction  Handshake                   Payload
// cmd       in         in_valid / in_ready         action, row_a, col_a, row_b, col_b,
//                                                  pattern_bit, color
// result    out        out_valid / out_ready       read_color, pixels_written
// config    in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// Single-pixel commands run accept, one access on the frame store port, then
// result load. Reads come back from the registered read port of the store.
// Fill/outline run accept, clip, walk, result load: fill walks its clipped area
// one pixel a cycle; outline walks its top and bottom rows, at most two per other row.
// No clearing pass after reset: the store is undefined until written.
// A finished result waits in the result state while the output register is still full.
module framebuffer_draw_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        action,
  input  logic signed [fde_pkg::FIELD_W-1:0] row_a,
  input  logic signed [fde_pkg::FIELD_W-1:0] col_a,
  input  logic signed [fde_pkg::FIELD_W-1:0] row_b,
  input  logic signed [fde_pkg::FIELD_W-1:0] col_b,
  input  logic                              pattern_bit,
  input  logic [fde_pkg::COLOR_W-1:0]       color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fde_pkg::COLOR_W-1:0]       read_color,
  output logic [fde_pkg::CNT_W-1:0]         pixels_written,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [fde_pkg::COLOR_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_PIX, S_CLIP, S_WALK, S_DONE} state_t;

  state_t state;

  logic [fde_pkg::DIM_W-1:0]   image_width;
  logic [fde_pkg::DIM_W-1:0]   image_height;
  logic [fde_pkg::COLOR_W-1:0] transparent_color;

  fde_pkg::action_t            act;
  logic                        outline;
  logic                        pat;
  logic [fde_pkg::COLOR_W-1:0] color_q;
  fde_pkg::coord_t             r0, c0, r1, c1, dr, dc;
  fde_pkg::coord_t             rlo, rhi, clo, chi;
  fde_pkg::coord_t             r, c;
  logic [fde_pkg::CNT_W-1:0]   n;
  logic                        rd_hit;

  logic [fde_pkg::COLOR_W-1:0] frame_store [fde_pkg::DEPTH];
  logic [fde_pkg::COLOR_W-1:0] rd_data;

  fde_pkg::coord_t             eff_w, eff_h;
  fde_pkg::coord_t             pr, pc;
  logic                        pix_hit, pix_en;
  fde_pkg::coord_t             rlo_next, rhi_next, clo_next, chi_next;
  logic                        rect_empty;
  fde_pkg::coord_t             c_step;
  logic                        row_end, edge_hit;
  logic                        mem_we;
  fde_pkg::coord_t             mem_row, mem_col;
  logic                        res_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign res_load  = (state == S_DONE) && (!out_valid || out_ready);

  assign eff_w = (int'(image_width) > fde_pkg::MAX_WIDTH) ?
                 fde_pkg::coord_t'(fde_pkg::MAX_WIDTH) : fde_pkg::coord_t'(image_width);
  assign eff_h = (int'(image_height) > fde_pkg::MAX_HEIGHT) ?
                 fde_pkg::coord_t'(fde_pkg::MAX_HEIGHT) : fde_pkg::coord_t'(image_height);

  // single pixel target; dr/dc are zero for plain write and read
  always_comb begin
    pr      = r0 + dr;
    pc      = c0 + dc;
    pix_hit = fde_pkg::in_frame(pr, pc, eff_h, eff_w);
    unique case (act)
      fde_pkg::ACT_WRITE:   pix_en = 1'b1;
      fde_pkg::ACT_OVERLAY: pix_en = (color_q != transparent_color);
      fde_pkg::ACT_PATTERN: pix_en = pat;
      default:              pix_en = 1'b0;
    endcase
  end

  // clip window
  always_comb begin
    rlo_next   = (r0 < 0) ? '0 : r0;
    clo_next   = (c0 < 0) ? '0 : c0;
    rhi_next   = (r1 > eff_h - 1) ? eff_h - 1 : r1;
    chi_next   = (c1 > eff_w - 1) ? eff_w - 1 : c1;
    rect_empty = (r0 > r1) || (c0 > c1) || (rlo_next > rhi_next) || (clo_next > chi_next);
  end

  // walk step: interior rows of an outline jump straight to the right edge
  always_comb begin
    c_step   = (outline && r != r0 && r != r1 && c < c1) ? c1 : c + 1'b1;
    row_end  = (c_step > chi);
    edge_hit = !outline || r == r0 || r == r1 || c == c0 || c == c1;
  end

  always_comb begin
    mem_row = r;
    mem_col = c;
    mem_we  = 1'b0;
    unique case (state)
      S_PIX: begin
        mem_row = pr;
        mem_col = pc;
        mem_we  = pix_hit && pix_en;
      end
      S_WALK:  mem_we = edge_hit;
      default: mem_we = 1'b0;
    endcase
  end

  // read data is held while the result waits
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[fde_pkg::pix_addr(mem_row, mem_col)] <= color_q;
    end
    if (state == S_PIX) begin
      rd_data <= frame_store[fde_pkg::pix_addr(mem_row, mem_col)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      image_width       <= fde_pkg::DIM_W'(256);
      image_height      <= fde_pkg::DIM_W'(256);
      transparent_color <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fde_pkg::CFG_WIDTH:  image_width       <= cfg_data[fde_pkg::DIM_W-1:0];
          fde_pkg::CFG_HEIGHT: image_height      <= cfg_data[fde_pkg::DIM_W-1:0];
          fde_pkg::CFG_TRANSP: transparent_color <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && !res_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act     <= fde_pkg::action_t'(action);
            outline <= (action == fde_pkg::ACT_OUTLINE);
            pat     <= pattern_bit;
            color_q <= color;
            r0      <= fde_pkg::coord_t'(row_a) - 1'b1;
            c0      <= fde_pkg::coord_t'(col_a) - 1'b1;
            r1      <= fde_pkg::coord_t'(row_b) - 1'b1;
            c1      <= fde_pkg::coord_t'(col_b) - 1'b1;
            n       <= '0;
            rd_hit  <= 1'b0;
            if (action == fde_pkg::ACT_OVERLAY || action == fde_pkg::ACT_PATTERN) begin
              dr <= fde_pkg::coord_t'(row_b);
              dc <= fde_pkg::coord_t'(col_b);
            end else begin
              dr <= '0;
              dc <= '0;
            end
            if (action == fde_pkg::ACT_FILL || action == fde_pkg::ACT_OUTLINE) begin
              state <= S_CLIP;
            end else if (action <= fde_pkg::ACT_PATTERN) begin
              state <= S_PIX;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PIX: begin
          n      <= fde_pkg::CNT_W'(pix_hit && pix_en);
          rd_hit <= pix_hit && (act == fde_pkg::ACT_READ);
          state  <= S_DONE;
        end
        S_CLIP: begin
          rlo <= rlo_next;
          rhi <= rhi_next;
          clo <= clo_next;
          chi <= chi_next;
          r   <= rlo_next;
          c   <= clo_next;
          state <= rect_empty ? S_DONE : S_WALK;
        end
        S_WALK: begin
          n <= n + fde_pkg::CNT_W'(edge_hit);
          if (row_end) begin
            c <= clo;
            r <= r + 1'b1;
            if (r == rhi) begin
              state <= S_DONE;
            end
          end else begin
            c <= c_step;
          end
        end
        S_DONE: begin
          if (res_load) begin
            out_valid      <= 1'b1;
            read_color     <= rd_hit ? rd_data : '0;
            pixels_written <= n;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "framebuffer_draw_engine_assert.svh"

  `FDE_ASSERT_NOW(a_write_in_frame, mem_we, fde_pkg::in_frame(mem_row, mem_col, eff_h, eff_w))
  `FDE_ASSERT_NOW(a_walk_in_window, state == S_WALK, r >= rlo && r <= rhi && c >= clo && c <= chi)
  `FDE_ASSERT_NEXT(a_result_loaded, res_load, out_valid && state == S_IDLE)

endmodule
